// ===== hw/rtl/bmf3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmf3_pkg
// Shared types and constants for the 3x3 box mean filter: payload words,
// register indexes, widths and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package bmf3_pkg;

   localparam int PIXEL_BITS        = 16;
   localparam int SUM_BITS          = PIXEL_BITS + 4;   // nine samples
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int WIDTH_REG_BITS    = 12;
   localparam int HEIGHT_REG_BITS   = 13;
   localparam int MAX_HEIGHT        = 4096;
   localparam int ROW_BITS          = 12;
   localparam int CSR_DATA_BITS     = 13;
   localparam int MIN_PADDED        = 3;

   // floor(x / 9) = (x * DIV9_MULT) >> DIV9_SHIFT, exact for x < 2**SUM_BITS
   localparam int DIV9_SHIFT = SUM_BITS + 3;
   localparam logic [SUM_BITS-1:0] DIV9_MULT =
      SUM_BITS'(((64'd1 << DIV9_SHIFT) + 64'd8) / 64'd9);
   localparam logic [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(4);

   typedef enum logic [0:0] {
      CSR_PADDED_WIDTH  = 1'b0,
      CSR_PADDED_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] mean_value;
      logic        row_end;
      logic        frame_end;
   } rsp_payload_type;

   // rounded mean of a nine-sample sum
   function automatic logic [15:0] mean_of_nine(input logic [SUM_BITS-1:0] sum);
      logic [SUM_BITS-1:0]   biased;
      logic [2*SUM_BITS-1:0] prod;
      biased = sum + ROUND_BIAS;
      prod   = {{SUM_BITS{1'b0}}, biased} * {{SUM_BITS{1'b0}}, DIV9_MULT};
      return prod[DIV9_SHIFT +: 16];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/box_mean_filter_3x3.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_mean_filter_3x3
// Streaming 3x3 box mean filter over a padded raster frame, with two line
// buffers in block memory and a nine-register window.
// ----------------------------------------------------------------------------
// A taken pixel word passes the line buffer read, window and sum, and the
// divide-by-nine output register on its way to rsp_. Border pixels give no
// result word. Throughput: one pixel word per cycle, set by the single read
// and write port of each line buffer, while the output is not stalled.
// Reset: synchronous, clears counters, window, pipeline valids and sets both
// size registers to 3. Line buffer contents are left as they are.
module box_mean_filter_3x3
   import bmf3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire csr_index_type            csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire req_payload_type          req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      rsp_payload_type          rsp_payload
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WCMP_BITS = (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;
   localparam logic [WCMP_BITS-1:0] W_MAX = WCMP_BITS'(MAX_WIDTH);
   localparam logic [WCMP_BITS-1:0] W_MIN = WCMP_BITS'(MIN_PADDED);
   localparam logic [HEIGHT_REG_BITS-1:0] H_MAX = HEIGHT_REG_BITS'(MAX_HEIGHT);
   localparam logic [HEIGHT_REG_BITS-1:0] H_MIN = HEIGHT_REG_BITS'(MIN_PADDED);

   // configuration
   logic [WIDTH_REG_BITS-1:0]  width_ff;
   logic [HEIGHT_REG_BITS-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_BITS'(MIN_PADDED);
         height_ff <= HEIGHT_REG_BITS'(MIN_PADDED);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PADDED_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_PADDED_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic [WCMP_BITS-1:0]       w_raw;
   logic [WCMP_BITS-1:0]       w_eff;
   logic [HEIGHT_REG_BITS-1:0] h_eff;

   always_comb begin
      w_raw = WCMP_BITS'(width_ff);
      if (w_raw < W_MIN)      w_eff = W_MIN;
      else if (w_raw > W_MAX) w_eff = W_MAX;
      else                    w_eff = w_raw;
      if (height_ff < H_MIN)      h_eff = H_MIN;
      else if (height_ff > H_MAX) h_eff = H_MAX;
      else                        h_eff = height_ff;
   end

   // handshake chain
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load, s2_adv, s2_free, s1_adv, accept;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && out_load;
   assign s2_free   = !s2_valid_ff || out_load;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign accept    = req_valid && req_ready;

   // position counters
   logic [COL_BITS-1:0]        col_ff, col_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;
   logic [COL_BITS-1:0]        col_cur;
   logic [ROW_BITS-1:0]        row_cur;
   logic [WCMP_BITS-1:0]       col_next;
   logic [HEIGHT_REG_BITS-1:0] row_next;
   logic                       last_col, last_row, emit;

   always_comb begin
      col_cur  = req_payload.frame_start ? '0 : col_ff;
      row_cur  = req_payload.frame_start ? '0 : row_ff;
      col_next = WCMP_BITS'(col_cur) + WCMP_BITS'(1);
      row_next = HEIGHT_REG_BITS'(row_cur) + HEIGHT_REG_BITS'(1);
      last_col = col_next >= w_eff;
      last_row = row_next >= h_eff;
      emit     = (row_cur >= ROW_BITS'(2)) && (col_cur >= COL_BITS'(2));
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[ROW_BITS-1:0];
         end else begin
            col_in = col_next[COL_BITS-1:0];
            row_in = row_cur;
         end
      end
   end

   // line buffers: a holds the previous row, b the row before that
   logic [PIXEL_BITS-1:0] line_buffer_a [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] line_buffer_b [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] mid_rd_ff;
   logic [PIXEL_BITS-1:0] top_rd_ff;

   // stage 1 payload
   logic [COL_BITS-1:0]   s1_addr_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic                  s1_emit_ff, s1_row_end_ff, s1_frame_end_ff;
   logic                  fwd_ff;
   logic [PIXEL_BITS-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff              <= line_buffer_a[col_cur];
         line_buffer_a[col_cur] <= req_payload.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= line_buffer_b[col_cur];
      end
      if (s1_adv) begin
         line_buffer_b[s1_addr_ff] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff      <= col_cur;
         s1_pixel_ff     <= req_payload.pixel;
         s1_emit_ff      <= emit;
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
         // same column again while its row-b write is still in flight
         fwd_ff          <= s1_valid_ff && (s1_addr_ff == col_cur);
         fwd_data_ff     <= mid_rd_ff;
      end
   end

   // window and sum
   logic [PIXEL_BITS-1:0] window_ff [9];
   logic [PIXEL_BITS-1:0] window_in [9];
   logic [PIXEL_BITS-1:0] top_pix;
   logic [SUM_BITS-1:0]   sum_in;

   always_comb begin
      top_pix = fwd_ff ? fwd_data_ff : top_rd_ff;
      for (int k = 0; k < 3; k++) begin
         window_in[k*3 + 0] = window_ff[k*3 + 1];
         window_in[k*3 + 1] = window_ff[k*3 + 2];
      end
      window_in[2] = top_pix;
      window_in[5] = mid_rd_ff;
      window_in[8] = s1_pixel_ff;
      sum_in = '0;
      for (int k = 0; k < 9; k++) begin
         sum_in = sum_in + SUM_BITS'(window_in[k]);
      end
   end

   logic [SUM_BITS-1:0] s2_sum_ff;
   logic                s2_row_end_ff, s2_frame_end_ff;
   rsp_payload_type     rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
      end else if (s1_adv) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_sum_ff       <= sum_in;
         s2_row_end_ff   <= s1_row_end_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
      end
      if (s2_adv) begin
         rsp_payload_ff.mean_value <= mean_of_nine(s2_sum_ff);
         rsp_payload_ff.row_end    <= s2_row_end_ff;
         rsp_payload_ff.frame_end  <= s2_frame_end_ff;
      end
   end

   // valids and counters
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? s1_emit_ff : (s2_adv ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a word entering stage 1 always pushes the previous one out
   assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> s1_adv)
      else $error("stage 1 overwritten before it moved on");

   // a held sum stays put while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_load) |=> (s2_valid_ff && $stable(s2_sum_ff)))
      else $error("stage 2 sum lost under output stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_payload_ff.frame_end || rsp_payload_ff.row_end))
      else $error("frame end without row end");

   assert property (@(posedge clock) disable iff (reset)
      WCMP_BITS'(col_ff) < W_MAX)
      else $error("column counter beyond line buffer depth");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for box_mean_filter_3x3. A short directed table of
// frames at the reset size is followed by random pixel streams over a list
// of frame sizes, small, clamped and the largest. Every accepted pixel word
// goes through a local model of the line buffers and window, and every
// result word is checked field by field against the oldest expected mean.
// ----------------------------------------------------------------------------
module tb_top;
   import bmf3_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 11;
   localparam int RSP_LATENCY  = 3;
   localparam int LONG_STALL   = 200;
   localparam int MAX_W        = MAX_WIDTH_DEFAULT;
   // roughly 1000 words; even with idle gaps and stalls this is far off
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_COUNT  = 9;

   typedef struct packed {
      logic [15:0]     pixel;
      logic            frame_start;
      logic            typed;
      rsp_payload_type want;
   } directed_row_type;

   typedef struct packed {
      logic [12:0] width_val;
      logic [12:0] height_val;
      int          words;
      logic        restarts;
      int          send_idle;
      int          recv_idle;
   } size_phase_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     csr_we      = 1'b0;
   csr_index_type            csr_index   = CSR_PADDED_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata   = '0;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   rsp_payload_type          rsp_payload;

   // local copy of the filter state
   logic [11:0]     cfg_width  = 12'd3;
   logic [12:0]     cfg_height = 13'd3;
   logic [15:0]     prev_row  [MAX_W];
   logic [15:0]     prev_row2 [MAX_W];
   logic [15:0]     window_px [9];
   int unsigned     col_pos = 0;
   int unsigned     row_pos = 0;

   rsp_payload_type expected_means [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   bit              stall_request  = 1'b0;

   directed_row_type directed_rows [29];
   size_phase_type   phases [PHASE_COUNT];

   box_mean_filter_3x3 dut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   initial begin
      for (int i = 0; i < MAX_W; i++) begin
         prev_row[i]  = '0;
         prev_row2[i] = '0;
      end
      for (int i = 0; i < 9; i++) begin
         window_px[i] = '0;
      end
   end

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v < MIN_PADDED) return MIN_PADDED;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the model by one pixel word, returns 1 when a mean comes out
   function automatic bit filter_pixel(input req_payload_type word,
                                       output rsp_payload_type mean);
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned col;
      int unsigned row;
      int unsigned c;
      int unsigned sum;
      logic [15:0] top;
      logic [15:0] mid;
      bit          hit;
      w_eff = clamp_size(cfg_width, MAX_W);
      h_eff = clamp_size(cfg_height, MAX_HEIGHT);
      if (word.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      col = col_pos;
      row = row_pos;
      c   = (col < MAX_W) ? col : MAX_W - 1;
      top = prev_row2[c];
      mid = prev_row[c];
      prev_row2[c] = mid;
      prev_row[c]  = word.pixel;
      for (int k = 0; k < 3; k++) begin
         window_px[k*3]     = window_px[k*3 + 1];
         window_px[k*3 + 1] = window_px[k*3 + 2];
      end
      window_px[2] = top;
      window_px[5] = mid;
      window_px[8] = word.pixel;
      mean = '0;
      hit  = 1'b0;
      if (row >= 2 && col >= 2) begin
         sum = 0;
         for (int k = 0; k < 9; k++) begin
            sum += window_px[k];
         end
         mean.mean_value = 16'((sum + 4) / 9);
         mean.row_end    = (col + 1 >= w_eff);
         mean.frame_end  = mean.row_end && (row + 1 >= h_eff);
         hit = 1'b1;
      end
      if (col + 1 >= w_eff) begin
         col_pos = 0;
         row_pos = (row + 1 >= h_eff) ? 0 : row + 1;
      end else begin
         col_pos = col + 1;
      end
      return hit;
   endfunction

   // offer one pixel word, wait for it to be taken, then log its mean if it has one
   task automatic send_word(input req_payload_type word, input logic typed,
                            input rsp_payload_type want);
      rsp_payload_type mean;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= word;
      do @(posedge clock); while (!req_ready);
      if (filter_pixel(word, mean)) begin
         expected_means.push_back(typed ? want : mean);
      end
   endtask

   // stop offering and let every pending mean come out, plus pipeline slack
   task automatic drain_means();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY) @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [12:0] width_val, input logic [12:0] height_val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PADDED_WIDTH;
      csr_wdata <= width_val;
      @(negedge clock);
      csr_index <= CSR_PADDED_HEIGHT;
      csr_wdata <= height_val;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_width  = width_val[11:0];
      cfg_height = height_val;
   endtask

   initial begin : stimulus
      req_payload_type word;
      size_phase_type  ph;
      directed_rows = '{
         // all-max frame at the reset size
         '{16'hFFFF, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
         // next frame with no start flag, counters wrap on their own
         '{16'hAAAA, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h5555, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hAAAA, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h5555, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hAAAA, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h5555, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hAAAA, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h5555, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'hAAAA, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         // partial row, then a restart in mid frame
         '{16'h1234, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h8001, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1}}
      };
      // width, height, words, mid-frame restarts, sender idle %, receiver idle %
      phases = '{
         '{13'd3,    13'd3,    100,  1'b1, 33, 75},
         '{13'd5,    13'd4,    150,  1'b1, 33, 75},
         '{13'd0,    13'd2,    100,  1'b1, 33, 75},
         '{13'd17,   13'd6,    150,  1'b1, 75, 33},
         '{13'd2,    13'd4096, 120,  1'b1, 75, 33},
         '{13'h1FFF, 13'd3,    64,   1'b0, 0,  0},
         '{13'd8,    13'd8191, 100,  1'b1, 0,  0},
         '{13'd33,   13'd5,    120,  1'b1, 0,  0},
         '{13'd4,    13'd1,    80,   1'b1, 0,  0}
      };
      send_idle_pct = 33;
      recv_idle_pct = 75;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(directed_rows); i++) begin
         word.pixel       = directed_rows[i].pixel;
         word.frame_start = directed_rows[i].frame_start;
         send_word(word, directed_rows[i].typed, directed_rows[i].want);
      end
      drain_means();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         ph = phases[p];
         send_idle_pct = ph.send_idle;
         recv_idle_pct = ph.recv_idle;
         set_frame_size(ph.width_val, ph.height_val);
         for (int n = 0; n < ph.words; n++) begin
            case ($urandom_range(7))
               0:       word.pixel = 16'h0000;
               1:       word.pixel = 16'hFFFF;
               default: word.pixel = 16'($urandom);
            endcase
            if (n == 0) begin
               word.frame_start = 1'b1;
            end else if (col_pos == 0 && row_pos == 0) begin
               word.frame_start = 1'($urandom_range(1));
            end else begin
               word.frame_start = ph.restarts && ($urandom_range(63) == 0);
            end
            // sender waits for the pipe to empty once, receiver stalls long once
            if (p == 1 && n == 75) drain_means();
            if (p == 2 && n == 30) stall_request = 1'b1;
            send_word(word, 1'b0, '0);
         end
         drain_means();
      end

      repeat (RSP_LATENCY + 2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin : receiver
      int held;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            for (held = 0; held < LONG_STALL; held++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : mean_checker
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            $display("%0t: unexpected result word, mean_value %0d row_end %0b frame_end %0b",
                     $time, rsp_payload.mean_value, rsp_payload.row_end,
                     rsp_payload.frame_end);
            mismatch_count++;
         end else begin
            want = expected_means.pop_front();
            if (rsp_payload.mean_value !== want.mean_value) begin
               $display("%0t: mean_value expected %0d, got %0d",
                        $time, want.mean_value, rsp_payload.mean_value);
               mismatch_count++;
            end
            if (rsp_payload.row_end !== want.row_end) begin
               $display("%0t: row_end expected %0b, got %0b",
                        $time, want.row_end, rsp_payload.row_end);
               mismatch_count++;
            end
            if (rsp_payload.frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %0b, got %0b",
                        $time, want.frame_end, rsp_payload.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d means still pending", $time, expected_means.size());
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
